[rtl/multi_button_debounce_event_core_defines.svh]
// Assertion macros used by the checker file of the debounce core.
`ifndef MULTI_BUTTON_DEBOUNCE_EVENT_CORE_DEFINES_SVH
`define MULTI_BUTTON_DEBOUNCE_EVENT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBDE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("debounce core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("debounce core: next-cycle check failed");

`endif

[rtl/mbde_pkg.sv]
`default_nettype none

package mbde_pkg;

    localparam int LEVEL_BITS   = 8;
    localparam int NOW_BITS     = 32;
    localparam int LOCKOUT_BITS = 8;
    localparam int CODE_BITS    = 4;

    localparam logic [LOCKOUT_BITS-1:0] LOCKOUT_RESET = 8'd45;
    localparam logic [CODE_BITS-1:0]    CODE_NONE     = 4'd0;

    // Per-button qualification status handed to the priority pick.
    typedef struct packed {
        logic qualified;
        logic press;
    } lane_status_t;

endpackage

`default_nettype wire

[rtl/mbde_lane.sv]
`default_nettype none

module mbde_lane #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   level,
    input  wire logic [TIME_BITS-1:0]                   now,
    input  wire logic [mbde_pkg::LOCKOUT_BITS-1:0]      lockout,
    input  wire logic                                   update,
    output mbde_pkg::lane_status_t                      status
);

    logic                 level_reg;
    logic                 level_next;
    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] time_next;
    logic [TIME_BITS-1:0] elapsed;

    // Wrapping subtraction gives the elapsed time modulo the timestamp width.
    assign elapsed = now - time_reg;

    always_comb
    begin
        status.qualified = (level != level_reg) && (elapsed > TIME_BITS'(lockout));
        status.press     = status.qualified && !level;
    end

    assign level_next = update ? level : level_reg;
    assign time_next  = update ? now : time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b1;
            time_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            time_reg  <= time_next;
        end
    end

endmodule

`default_nettype wire

[rtl/mbde_prio.sv]
`default_nettype none

module mbde_prio #(
    parameter int NUM_BUTTONS = 8
) (
    input  wire mbde_pkg::lane_status_t [NUM_BUTTONS-1:0] status,
    output logic [NUM_BUTTONS-1:0]                      allow,
    output logic [mbde_pkg::CODE_BITS-1:0]              code
);

    // A button may update only if no lower-index button reports a press.
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            allow[i] = !seen;
            seen     = seen | status[i].press;
        end
    end

    always_comb
    begin
        code = mbde_pkg::CODE_NONE;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (status[i].press)
            begin
                code = mbde_pkg::CODE_BITS'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/multi_button_debounce_event_core.sv]
// An accepted sample's event code is registered once the result register is free.
// Throughput: one sample per cycle while no held result stalls the output; the
// button state updates at the same edge as the result register, so the following
// sample sees it at once.
// Reset (rst_n low, asynchronous): all buttons idle with change time zero,
// lockout back to 45 ms, both pipeline registers empty.
`default_nettype none

module multi_button_debounce_event_core #(
    parameter int NUM_BUTTONS = 8,
    parameter int TIME_BITS   = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [mbde_pkg::LOCKOUT_BITS-1:0]      cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [mbde_pkg::LEVEL_BITS-1:0]        button_levels,
    input  wire logic [mbde_pkg::NOW_BITS-1:0]          now_ms,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [mbde_pkg::CODE_BITS-1:0]              event_code
);

    logic [mbde_pkg::LOCKOUT_BITS-1:0] lockout_reg;
    logic                              s1_valid_reg;
    logic [mbde_pkg::LEVEL_BITS-1:0]   levels_reg;
    logic [mbde_pkg::NOW_BITS-1:0]     now_reg;
    logic                              out_valid_reg;
    logic [mbde_pkg::CODE_BITS-1:0]    event_code_reg;

    logic                              advance;
    logic                              commit;
    logic                              accept;
    logic [TIME_BITS-1:0]              now_ext;
    logic [NUM_BUTTONS-1:0]            lane_level;
    logic [NUM_BUTTONS-1:0]            allow;
    logic [mbde_pkg::CODE_BITS-1:0]    pick_code;

    mbde_pkg::lane_status_t [NUM_BUTTONS-1:0] status;

    assign advance   = !out_valid_reg || out_ready;
    assign commit    = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign accept    = in_valid && in_ready;
    assign now_ext   = TIME_BITS'(now_reg);
    assign out_valid = out_valid_reg;
    assign event_code = event_code_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_BUTTONS; g++)
        begin : g_lane
            // Buttons past the sampled field read as pressed.
            if (g < mbde_pkg::LEVEL_BITS)
            begin : g_pin
                assign lane_level[g] = levels_reg[g];
            end
            else
            begin : g_none
                assign lane_level[g] = 1'b0;
            end

            mbde_lane #(
                .TIME_BITS(TIME_BITS)
            ) u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .level   (lane_level[g]),
                .now     (now_ext),
                .lockout (lockout_reg),
                .update  (commit && status[g].qualified && allow[g]),
                .status  (status[g])
            );
        end
    endgenerate

    mbde_prio #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_prio (
        .status (status),
        .allow  (allow),
        .code   (pick_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg   <= mbde_pkg::LOCKOUT_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lockout_reg <= cfg_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            levels_reg <= button_levels;
            now_reg    <= now_ms;
        end
        if (commit)
        begin
            event_code_reg <= pick_code;
        end
    end

endmodule

`default_nettype wire

[rtl/mbde_checker.sv]
`default_nettype none

`include "multi_button_debounce_event_core_defines.svh"

module mbde_checker #(
    parameter int NUM_BUTTONS = 8
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic [mbde_pkg::CODE_BITS-1:0]      event_code
);

    // A stalled result keeps its code.
    `MBDE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(event_code))

    // With the result register empty the input side never stalls.
    `MBDE_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // A new result follows its taken transaction through the input and result registers.
    `MBDE_ASSERT_SAME(a_result_latency, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

    // Codes name an existing button unless they had to wrap.
    `MBDE_ASSERT_SAME(a_code_range, clk, rst_n, out_valid, (NUM_BUTTONS >= 15) || (event_code <= NUM_BUTTONS))

endmodule

bind multi_button_debounce_event_core mbde_checker #(
    .NUM_BUTTONS(NUM_BUTTONS)
) u_mbde_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_code (event_code)
);

`default_nettype wire
